### rtl/core/mfpr_pkg.sv
// ----------------------------------------------------------------------------
// mfpr_pkg
// Shared types and constants for the motion FIFO packet receiver core.
// ----------------------------------------------------------------------------
package mfpr_pkg;

  // Packet layout
  localparam int PACKET_BYTES  = 42;
  localparam int WORDS_KEPT    = 7;
  localparam int CAPTURE_BYTES = 4 * WORDS_KEPT;

  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(PACKET_BYTES - 1);
  localparam logic [IDX_W-1:0] FOOTER_INDEX  = IDX_W'(PACKET_BYTES - 2);
  localparam logic [IDX_W-1:0] CAPTURE_LIMIT = IDX_W'(CAPTURE_BYTES);

  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(PACKET_BYTES);

  localparam logic [7:0] EMPTY_LIMIT_RESET = 8'd200;
  localparam logic [7:0] EMPTY_COUNT_TOP   = 8'hFF;

  // Input opcodes
  localparam logic [1:0] OP_IRQ  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_FAIL = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_RESET   = 3'd1;
  localparam logic [2:0] KIND_MOTION  = 3'd2;
  localparam logic [2:0] KIND_CORRUPT = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Register indexes
  localparam logic [1:0] CFG_FOOTER = 2'd0;
  localparam logic [1:0] CFG_RUN    = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COUNT_W-1:0] fifo_count;
    logic [7:0]         data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] rate_yaw;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] rate_roll;
    logic               first_setup;
  } result_t;

  typedef struct packed {
    logic [15:0] footer_value;
    logic        run_enable;
    logic [7:0]  empty_limit;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] byte_index;
    logic             first_pending;
  } dl_state_t;

endpackage

### rtl/core/mfpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfpr_cfg_regs
// Configuration register file: footer, run enable and empty limit.
// ----------------------------------------------------------------------------
module mfpr_cfg_regs
  import mfpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // always ready, writes are registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.footer_value <= '0;
      cfg.run_enable   <= 1'b0;
      cfg.empty_limit  <= EMPTY_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FOOTER: cfg.footer_value <= cfg_data;
        CFG_RUN:    cfg.run_enable   <= cfg_data[0];
        CFG_LIMIT:  cfg.empty_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/mfpr_in_reg.sv
// ----------------------------------------------------------------------------
// mfpr_in_reg
// Input register: holds one accepted item until the decode stage takes it.
// ----------------------------------------------------------------------------
module mfpr_in_reg
  import mfpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [COUNT_W-1:0] fifo_count,
  input  logic [7:0]         data_byte,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               take
);

  logic load;

  // stall only while a held item is not being taken
  assign in_stall = q_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      q_item.opcode     <= opcode;
      q_item.fifo_count <= fifo_count;
      q_item.data_byte  <= data_byte;
    end
  end

endmodule

### rtl/core/mfpr_engine.sv
// ----------------------------------------------------------------------------
// mfpr_engine
// Decode stage: download state, empty counter, word capture, footer check.
// ----------------------------------------------------------------------------
module mfpr_engine
  import mfpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  item_t     q_item,
  input  logic      out_free,
  output logic      take,
  output logic      res_valid,
  output result_t   res,
  output dl_state_t status
);

  logic             busy;
  logic             busy_next;
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic [7:0]       empty_count;
  logic [7:0]       empty_count_next;
  logic [7:0]       empty_bumped;
  logic             first_pending;
  logic             first_pending_next;
  logic [15:0]      words [WORDS_KEPT];
  logic [7:0]       footer_low_byte;
  logic             byte_take;

  assign empty_bumped = (empty_count == EMPTY_COUNT_TOP) ? empty_count
                                                         : empty_count + 8'd1;

  // next state and result for the held item
  always_comb begin
    busy_next          = busy;
    byte_index_next    = byte_index;
    empty_count_next   = empty_count;
    first_pending_next = first_pending;
    res_valid          = 1'b0;
    res                = '0;
    if (q_valid) begin
      case (q_item.opcode)
        OP_IRQ: begin
          if (cfg.run_enable && !busy) begin
            if (q_item.fifo_count < COUNT_MIN) begin
              empty_count_next = empty_bumped;
              if (empty_bumped >= cfg.empty_limit) begin
                res_valid = 1'b1;
                res.kind  = KIND_RESET;
              end
            end else begin
              busy_next        = 1'b1;
              byte_index_next  = '0;
              empty_count_next = '0;
              res_valid        = 1'b1;
              res.kind         = KIND_START;
            end
          end
        end
        OP_BYTE: begin
          if (busy) begin
            if (byte_index == LAST_INDEX) begin
              busy_next       = 1'b0;
              byte_index_next = '0;
              res_valid       = 1'b1;
              if ({q_item.data_byte, footer_low_byte} == cfg.footer_value) begin
                first_pending_next = 1'b0;
                res.kind        = KIND_MOTION;
                res.quat_w      = words[0];
                res.quat_x      = words[1];
                res.quat_y      = words[2];
                res.quat_z      = words[3];
                res.rate_yaw    = words[6];
                res.rate_pitch  = words[4];
                res.rate_roll   = words[5];
                res.first_setup = first_pending;
              end else begin
                res.kind = KIND_CORRUPT;
              end
            end else begin
              byte_index_next = byte_index + IDX_W'(1);
            end
          end
        end
        OP_FAIL: begin
          if (busy) begin
            busy_next       = 1'b0;
            byte_index_next = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
          end
        end
        default: ;
      endcase
    end
  end

  // items with no result never wait on the output side
  assign take      = q_valid && (!res_valid || out_free);
  assign byte_take = take && busy && (q_item.opcode == OP_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      byte_index    <= '0;
      empty_count   <= '0;
      first_pending <= 1'b1;
    end else if (take) begin
      busy          <= busy_next;
      byte_index    <= byte_index_next;
      empty_count   <= empty_count_next;
      first_pending <= first_pending_next;
    end
  end

  // word capture: big-endian, top half of each 32-bit word
  always_ff @(posedge clk) begin
    if (byte_take && (byte_index < CAPTURE_LIMIT)) begin
      if (byte_index[1:0] == 2'd0) begin
        words[byte_index[4:2]][15:8] <= q_item.data_byte;
      end else if (byte_index[1:0] == 2'd1) begin
        words[byte_index[4:2]][7:0] <= q_item.data_byte;
      end
    end
    if (byte_take && (byte_index == FOOTER_INDEX)) begin
      footer_low_byte <= q_item.data_byte;
    end
  end

  assign status.busy          = busy;
  assign status.byte_index    = byte_index;
  assign status.first_pending = first_pending;

endmodule

### rtl/core/mfpr_out_reg.sv
// ----------------------------------------------------------------------------
// mfpr_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module mfpr_out_reg
  import mfpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t q
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= res;
    end
  end

endmodule

### rtl/core/motion_fifo_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// motion_fifo_packet_receiver_core
// Paces and checks downloads of 42-byte motion packets from a sensor FIFO.
// ----------------------------------------------------------------------------
// Takes one item per clock while the input register is not stalled. An accepted
// item sits in the input register and is decoded there; if it produces a
// result, it is then loaded into the result register. Items with no result
// pass the decode stage even while the result register is stalled; an item
// with a result waits in the input register until the result register is
// free. Configuration writes are registered and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module motion_fifo_packet_receiver_core
  import mfpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [COUNT_W-1:0]  fifo_count,
  input  logic [7:0]          data_byte,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          kind,
  output logic signed [15:0]  quat_w,
  output logic signed [15:0]  quat_x,
  output logic signed [15:0]  quat_y,
  output logic signed [15:0]  quat_z,
  output logic signed [15:0]  rate_yaw,
  output logic signed [15:0]  rate_pitch,
  output logic signed [15:0]  rate_roll,
  output logic                first_setup,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  cfg_t      cfg;
  logic      q_valid;
  item_t     q_item;
  logic      take;
  logic      res_valid;
  result_t   res;
  dl_state_t status;
  logic      out_free;
  result_t   out_q;

  mfpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mfpr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .fifo_count (fifo_count),
    .data_byte  (data_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .take       (take)
  );

  mfpr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  mfpr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (out_q)
  );

  assign kind        = out_q.kind;
  assign quat_w      = out_q.quat_w;
  assign quat_x      = out_q.quat_x;
  assign quat_y      = out_q.quat_y;
  assign quat_z      = out_q.quat_z;
  assign rate_yaw    = out_q.rate_yaw;
  assign rate_pitch  = out_q.rate_pitch;
  assign rate_roll   = out_q.rate_roll;
  assign first_setup = out_q.first_setup;

`ifndef NO_ASSERTIONS
  // byte counter is parked at zero whenever no download runs
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !status.busy |-> (status.byte_index == '0))
    else $error("byte index non-zero outside a download");

  // a start result always leaves a download running
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && (res.kind == KIND_START)) |=> status.busy)
    else $error("download not running after start");

  // setup flag shown only once the pending flag has been spent
  a_setup_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_MOTION) && first_setup) |-> !status.first_pending)
    else $error("first setup reported while still pending");

  // quat_w, quat_x, rate_yaw and first_setup are zero on every non-motion result
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_MOTION)) |->
      ((quat_w == 16'sd0) && (quat_x == 16'sd0) && (rate_yaw == 16'sd0) &&
       (first_setup == 1'b0)))
    else $error("data on a non-motion result");
`endif

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motion FIFO packet receiver core.
// ----------------------------------------------------------------------------
// Interrupts, packet bytes and download failures are driven in random bursts,
// and the result side is stalled on a shifting pattern. Each accepted item is
// run through a behavioural deframer held in a small class. Results are
// checked field by field, in order, against the queue of due results. The
// register settings are changed between phases, with the block drained first.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfpr_pkg::*;

  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int FIFO_BYTES     = 1024;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 120;
  localparam int PHASE_ITEMS    = 30;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_mode_e;

  // Behavioural deframer: register copy, download state and due results
  class deframer_model;
    logic [15:0]      footer;
    logic             run_on;
    logic [7:0]       limit;
    logic             busy;
    logic [IDX_W-1:0] idx;
    logic [7:0]       empties;
    logic             first_pend;
    logic [15:0]      words [WORDS_KEPT];
    logic [7:0]       footer_lo;
    result_t          due_results [$];
    int               fails;

    function new();
      footer     = '0;
      run_on     = 1'b0;
      limit      = EMPTY_LIMIT_RESET;
      busy       = 1'b0;
      idx        = '0;
      empties    = '0;
      first_pend = 1'b1;
      footer_lo  = '0;
      fails      = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void set_reg(logic [1:0] index, logic [15:0] value);
      case (index)
        CFG_FOOTER: footer = value;
        CFG_RUN:    run_on = value[0];
        CFG_LIMIT:  limit  = value[7:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the item changes state or causes a result
    function bit take_item(logic [1:0] op, logic [COUNT_W-1:0] cnt, logic [7:0] b);
      result_t r;
      bit      effect;
      r      = '0;
      effect = 1'b0;
      case (op)
        OP_IRQ: begin
          if (run_on && !busy) begin
            effect = 1'b1;
            if (cnt < COUNT_MIN) begin
              if (empties != EMPTY_COUNT_TOP) empties++;
              if (empties >= limit) begin
                r.kind = KIND_RESET;
                due_results.push_back(r);
              end
            end else begin
              busy    = 1'b1;
              idx     = '0;
              empties = '0;
              r.kind  = KIND_START;
              due_results.push_back(r);
            end
          end
        end
        OP_BYTE: begin
          if (busy) begin
            effect = 1'b1;
            // keep the top half of each big-endian word
            if (idx < CAPTURE_LIMIT) begin
              if (idx[1:0] == 2'd0) words[idx[IDX_W-1:2]][15:8] = b;
              else if (idx[1:0] == 2'd1) words[idx[IDX_W-1:2]][7:0] = b;
            end
            if (idx == FOOTER_INDEX) footer_lo = b;
            if (idx != LAST_INDEX) begin
              idx++;
            end else begin
              busy = 1'b0;
              idx  = '0;
              if ({b, footer_lo} == footer) begin
                r.kind        = KIND_MOTION;
                r.quat_w      = words[0];
                r.quat_x      = words[1];
                r.quat_y      = words[2];
                r.quat_z      = words[3];
                r.rate_yaw    = words[6];
                r.rate_pitch  = words[4];
                r.rate_roll   = words[5];
                r.first_setup = first_pend;
                first_pend    = 1'b0;
              end else begin
                r.kind = KIND_CORRUPT;
              end
              due_results.push_back(r);
            end
          end
        end
        OP_FAIL: begin
          if (busy) begin
            effect = 1'b1;
            busy   = 1'b0;
            idx    = '0;
            r.kind = KIND_ERROR;
            due_results.push_back(r);
          end
        end
        default: ;
      endcase
      return effect;
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("kind: expected no result, got %0d", got.kind);
        fails++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind",        want.kind,        got.kind);
      compare_field("quat_w",      want.quat_w,      got.quat_w);
      compare_field("quat_x",      want.quat_x,      got.quat_x);
      compare_field("quat_y",      want.quat_y,      got.quat_y);
      compare_field("quat_z",      want.quat_z,      got.quat_z);
      compare_field("rate_yaw",    want.rate_yaw,    got.rate_yaw);
      compare_field("rate_pitch",  want.rate_pitch,  got.rate_pitch);
      compare_field("rate_roll",   want.rate_roll,   got.rate_roll);
      compare_field("first_setup", want.first_setup, got.first_setup);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          opcode;
  logic [COUNT_W-1:0]  fifo_count;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          kind;
  logic signed [15:0]  quat_w;
  logic signed [15:0]  quat_x;
  logic signed [15:0]  quat_y;
  logic signed [15:0]  quat_z;
  logic signed [15:0]  rate_yaw;
  logic signed [15:0]  rate_pitch;
  logic signed [15:0]  rate_roll;
  logic                first_setup;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_data;

  deframer_model model;
  int          burst_left;
  int          useful_items;
  int          stall_tick;
  stall_mode_e stall_mode;
  int          quiet_cycles;

  motion_fifo_packet_receiver_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .fifo_count  (fifo_count),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .rate_yaw    (rate_yaw),
    .rate_pitch  (rate_pitch),
    .rate_roll   (rate_roll),
    .first_setup (first_setup),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  // Result-side stall on a pattern that is redrawn at random from time to time
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall <= (stall_tick % 7) < 4;
      default:        out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    result_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.kind        = kind;
      seen.quat_w      = quat_w;
      seen.quat_x      = quat_x;
      seen.quat_y      = quat_y;
      seen.quat_z      = quat_z;
      seen.rate_yaw    = rate_yaw;
      seen.rate_pitch  = rate_pitch;
      seen.rate_roll   = rate_roll;
      seen.first_setup = first_setup;
      model.match_result(seen);
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("motion_fifo_packet_receiver_core: mismatch");
        $finish;
      end
    end
  end

  // One item, with a random gap at the start of each burst
  task automatic send_item(input logic [1:0] op, input logic [COUNT_W-1:0] cnt,
                           input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    opcode     <= op;
    fifo_count <= cnt;
    data_byte  <= b;
    do @(posedge clk); while (in_stall);
    if (model.take_item(op, cnt, b)) useful_items++;
  endtask

  // Packet bytes from..upto-1; footer taken from the current register value, one bit flipped when not good
  task automatic send_bytes(input int from, input int upto, input bit good,
                            input bit extreme, input bit noisy);
    logic [15:0] foot;
    logic [7:0]  v;
    foot = model.footer ^ (good ? 16'h0000 : (16'h0001 << $urandom_range(0, 15)));
    for (int i = from; i < upto; i++) begin
      // stray interrupt or spare opcode mid-download
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_item(($urandom_range(0, 1) == 0) ? OP_IRQ : OP_SPARE,
                  COUNT_W'($urandom), 8'($urandom));
      end
      if (i == PACKET_BYTES - 2) v = foot[7:0];
      else if (i == PACKET_BYTES - 1) v = foot[15:8];
      else if (extreme) begin
        case ($urandom_range(0, 3))
          0:       v = 8'h00;
          1:       v = 8'hFF;
          2:       v = 8'h80;
          default: v = 8'h7F;
        endcase
      end else begin
        v = 8'($urandom);
      end
      send_item(OP_BYTE, COUNT_W'($urandom), v);
    end
  endtask

  // Wait for every due result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (model.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(index, value);
  endtask

  // All registers written back to back; unused bits carry random values
  task automatic apply_settings(input logic [15:0] foot, input logic run,
                                input logic [7:0] lim);
    write_reg(CFG_FOOTER, foot);
    write_reg(CFG_RUN, {15'($urandom), run});
    write_reg(CFG_LIMIT, {8'($urandom), lim});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [15:0] foot;
    logic [7:0]  lim;
    case ($urandom_range(0, 3))
      0:       foot = 16'h0000;
      1:       foot = 16'hFFFF;
      default: foot = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       lim = 8'h00;
      1:       lim = 8'h01;
      2:       lim = 8'hFF;
      default: lim = 8'($urandom_range(2, 10));
    endcase
    apply_settings(foot, 1'b1, lim);
  endtask

  task automatic random_sequence();
    int          pick;
    int          n;
    logic [10:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // download: mostly whole packets, some cut short by a failure
      cnt = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(COUNT_MIN, 2047))
                                         : 11'($urandom_range(COUNT_MIN, FIFO_BYTES));
      send_item(OP_IRQ, cnt, 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        send_bytes(0, $urandom_range(0, PACKET_BYTES - 1), 1'b1, 1'b0, 1'b1);
        send_item(OP_FAIL, COUNT_W'($urandom), 8'($urandom));
      end else begin
        send_bytes(0, PACKET_BYTES, $urandom_range(0, 3) != 0,
                   $urandom_range(0, 3) == 0, 1'b1);
      end
    end else if (pick < 85) begin
      n = $urandom_range(1, 12);
      repeat (n) send_item(OP_IRQ, 11'($urandom_range(0, COUNT_MIN - 1)), 8'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0:       send_item(OP_BYTE, COUNT_W'($urandom), 8'($urandom));
        1:       send_item(OP_FAIL, COUNT_W'($urandom), 8'($urandom));
        2:       send_item(OP_SPARE, COUNT_W'($urandom), 8'($urandom));
        default: send_item(OP_IRQ, COUNT_W'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic run_directed();
    // stopped after reset: everything is ignored
    send_item(OP_IRQ, 11'd1024, 8'h00);
    send_item(OP_BYTE, 11'h7FF, 8'hFF);
    send_item(OP_FAIL, 11'd0, 8'h00);
    send_item(OP_SPARE, 11'h7FF, 8'hFF);
    settle();
    apply_settings(16'hBEEF, 1'b1, 8'd2);
    // empty counter reaches the limit, then keeps asking
    send_item(OP_IRQ, 11'd0, 8'hFF);
    send_item(OP_IRQ, COUNT_MIN - 11'd1, 8'h00);
    send_item(OP_IRQ, 11'd0, 8'h00);
    // download start; interrupt and spare opcode while busy are ignored
    send_item(OP_IRQ, COUNT_MIN, 8'h00);
    send_item(OP_IRQ, 11'h7FF, 8'h00);
    send_item(OP_SPARE, 11'd0, 8'h00);
    send_bytes(0, PACKET_BYTES, 1'b1, 1'b1, 1'b0);
    // failure mid-download, then failure and byte with no download
    send_item(OP_IRQ, 11'd1024, 8'h00);
    send_bytes(0, 10, 1'b1, 1'b0, 1'b0);
    send_item(OP_FAIL, 11'd0, 8'h00);
    send_item(OP_FAIL, 11'd0, 8'h00);
    send_item(OP_BYTE, 11'd0, 8'h55);
    // enable cleared part way through: the download still completes
    send_item(OP_IRQ, 11'd100, 8'h00);
    send_bytes(0, 20, 1'b1, 1'b0, 1'b0);
    settle();
    apply_settings(16'hBEEF, 1'b0, 8'd2);
    send_bytes(20, PACKET_BYTES, 1'b0, 1'b0, 1'b0);
    send_item(OP_IRQ, 11'd1024, 8'h00);
    settle();
  endtask

  task automatic run_random();
    int phase;
    int mark;
    // empty counter saturates at its top with the largest limit
    apply_settings(16'hFFFF, 1'b1, 8'hFF);
    repeat (260) send_item(OP_IRQ, 11'($urandom_range(0, COUNT_MIN - 1)), 8'($urandom));
    random_sequence();
    settle();
    useful_items = 0;
    phase = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if (phase % 4 == 3) begin
        // short stopped stretch
        apply_settings(model.footer, 1'b0, model.limit);
        repeat (3) random_sequence();
        settle();
      end
      pick_settings();
      mark = useful_items;
      while (useful_items < mark + PHASE_ITEMS) random_sequence();
      settle();
      phase++;
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = '0;
    fifo_count   = '0;
    data_byte    = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    burst_left   = 0;
    useful_items = 0;
    stall_tick   = 0;
    stall_mode   = STALL_NONE;
    quiet_cycles = 0;
    model        = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.fails == 0) begin
      $display("motion_fifo_packet_receiver_core: match");
    end else begin
      $display("motion_fifo_packet_receiver_core: mismatch");
    end
    $finish;
  end

endmodule
